/* src/pvga_pkg.sv */
// shared types, command codes and color helpers of the planar palette scanout unit
package pvga_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    localparam logic [2:0] CMD_WRITE   = 3'd0;
    localparam logic [2:0] CMD_BEGIN   = 3'd1;
    localparam logic [2:0] CMD_ENTRY18 = 3'd2;
    localparam logic [2:0] CMD_ENTRY15 = 3'd3;
    localparam logic [2:0] CMD_PIXEL   = 3'd4;

    localparam logic [8:0] PTR_IDLE = 9'd256;

    typedef enum logic [2:0] {
        OP_WRITE,
        OP_BEGIN,
        OP_ENTRY,
        OP_PIXEL,
        OP_BLANK
    } op_t;

    // data: write byte in [7:0]; begin {count, start}; entry {r, g, b}
    typedef struct packed {
        op_t         op;
        logic [1:0]  plane;
        logic [15:0] offset;
        logic [23:0] data;
    } q_entry_t;

    function automatic logic [7:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [7:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

endpackage

/* src/pvga_front.sv */
// front end: accepts transactions, classifies them and forms plane addresses
module pvga_front #(
    parameter int PLANE_BYTES   = 65536,
    parameter int LINE_STRIDE   = 160,
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 400
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [103:0]         s_tdata,
    input  logic [2:0]           s_tuser,
    output logic                 q_push,
    output pvga_pkg::q_entry_t   q_entry,
    input  logic                 q_ready
);
    import pvga_pkg::*;

    localparam logic [18:0] PB1 = 19'(PLANE_BYTES);
    localparam logic [18:0] PB2 = 19'(2 * PLANE_BYTES);
    localparam logic [18:0] PB4 = 19'(4 * PLANE_BYTES);

    logic [1:0]  f_plane;
    logic [15:0] f_offset;
    logic [7:0]  f_byte;
    logic [7:0]  f_start;
    logic [15:0] f_count;
    logic [17:0] f_color18;
    logic [15:0] f_packed15;
    logic [9:0]  f_x;
    logic [8:0]  f_y;

    logic        st_valid_reg, st_valid_next;
    op_t         st_op_reg, cls_op;
    logic [1:0]  st_plane_reg, cls_plane;
    logic [16:0] st_off_reg, cls_off;
    logic [23:0] st_data_reg, cls_data;
    logic        cls_keep;
    logic        take;
    logic [18:0] r_a, r_b, r_c;

    assign f_plane    = s_tdata[1:0];
    assign f_offset   = s_tdata[17:2];
    assign f_byte     = s_tdata[25:18];
    assign f_start    = s_tdata[33:26];
    assign f_count    = s_tdata[49:34];
    assign f_color18  = s_tdata[67:50];
    assign f_packed15 = s_tdata[83:68];
    assign f_x        = s_tdata[93:84];
    assign f_y        = s_tdata[102:94];

    always_comb begin
        cls_keep  = 1'b1;
        cls_op    = OP_WRITE;
        cls_plane = f_plane;
        cls_off   = {1'b0, f_offset};
        cls_data  = {16'd0, f_byte};
        unique case (s_tuser)
            CMD_WRITE: begin
                cls_op = OP_WRITE;
            end
            CMD_BEGIN: begin
                cls_op   = OP_BEGIN;
                cls_data = {f_count, f_start};
            end
            CMD_ENTRY18: begin
                cls_op   = OP_ENTRY;
                cls_data = {widen6(f_color18[17:12]), widen6(f_color18[11:6]),
                            widen6(f_color18[5:0])};
            end
            CMD_ENTRY15: begin
                cls_op   = OP_ENTRY;
                cls_data = {widen5(f_packed15[14:10]), widen5(f_packed15[9:5]),
                            widen5(f_packed15[4:0])};
            end
            CMD_PIXEL: begin
                cls_plane = f_x[1:0];
                cls_off   = 17'(17'(f_y) * 17'(LINE_STRIDE)) + 17'(f_x[9:2]);
                if ((32'(f_x) < 32'(SCREEN_WIDTH)) && (32'(f_y) < 32'(SCREEN_HEIGHT))) begin
                    cls_op = OP_PIXEL;
                end else begin
                    cls_op = OP_BLANK;
                end
            end
            default: begin
                cls_keep = 1'b0;
            end
        endcase
    end

    // wrap the offset into the plane
    always_comb begin
        r_a = {2'b00, st_off_reg};
        if (r_a >= PB4) begin
            r_a = r_a - PB4;
        end
        r_b = r_a;
        if (r_b >= PB2) begin
            r_b = r_b - PB2;
        end
        r_c = r_b;
        if (r_c >= PB1) begin
            r_c = r_c - PB1;
        end
    end

    assign q_push         = st_valid_reg && q_ready;
    assign q_entry.op     = st_op_reg;
    assign q_entry.plane  = st_plane_reg;
    assign q_entry.offset = r_c[15:0];
    assign q_entry.data   = st_data_reg;

    assign s_tready = !st_valid_reg || q_ready;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        st_valid_next = st_valid_reg;
        if (take) begin
            st_valid_next = cls_keep;
        end else if (q_push) begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            st_op_reg    <= cls_op;
            st_plane_reg <= cls_plane;
            st_off_reg   <= cls_off;
            st_data_reg  <= cls_data;
        end
    end

endmodule

/* src/pvga_fifo.sv */
// short command queue between the front end and the back end
module pvga_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  pvga_pkg::q_entry_t   push_entry,
    output logic                 not_full,
    input  logic                 pop,
    output logic                 not_empty,
    output pvga_pkg::q_entry_t   head
);
    import pvga_pkg::*;

    q_entry_t         slot_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]     count_reg, count_next;
    logic             do_push, do_pop;

    assign not_full  = count_reg != (QAW + 1)'(QDEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* src/pvga_back.sv */
// back end: plane memory, palette memory, load pointer and result register
module pvga_back #(
    parameter int PLANE_BYTES = 65536
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  pvga_pkg::q_entry_t   q_entry,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata
);
    import pvga_pkg::*;

    localparam int AW          = $clog2(PLANE_BYTES);
    localparam int PLANE_WORDS = 4 * (2 ** AW);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_PLANE = 4'b0010,
        ST_PAL   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t       state_reg, state_next;
    logic [8:0]   ptr_reg, ptr_next;
    logic [15:0]  left_reg, left_next;
    logic [23:0]  out_reg, out_next;

    logic [7:0]   plane_mem [PLANE_WORDS];
    logic [23:0]  pal_mem [256];
    logic [255:0] pal_valid_reg;

    logic [AW+1:0] plane_addr;
    logic          plane_we;
    logic          pal_we;
    logic [7:0]    plane_q_reg;
    logic [23:0]   pal_q_reg;
    logic          pal_v_reg;
    logic [7:0]    idx_q_reg;

    assign plane_addr = {q_entry.plane, q_entry.offset[AW-1:0]};
    assign q_pop      = (state_reg == ST_IDLE) && q_valid;
    assign plane_we   = q_pop && (q_entry.op == OP_WRITE);
    assign pal_we     = q_pop && (q_entry.op == OP_ENTRY) && (left_reg != 16'd0) && !ptr_reg[8];

    assign m_tvalid = state_reg == ST_OUT;
    assign m_tdata  = {out_reg[7:0], out_reg[15:8], out_reg[23:16]};

    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        left_next  = left_reg;
        out_next   = out_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    unique case (q_entry.op)
                        OP_BEGIN: begin
                            ptr_next  = {1'b0, q_entry.data[7:0]};
                            left_next = q_entry.data[23:8];
                        end
                        OP_ENTRY: begin
                            if (pal_we) begin
                                ptr_next  = ptr_reg + 9'd1;
                                left_next = left_reg - 16'd1;
                            end
                        end
                        OP_PIXEL: begin
                            state_next = ST_PLANE;
                        end
                        OP_BLANK: begin
                            out_next   = 24'd0;
                            state_next = ST_OUT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PLANE: begin
                state_next = ST_PAL;
            end
            ST_PAL: begin
                out_next   = pal_v_reg ? pal_q_reg : {idx_q_reg, idx_q_reg, idx_q_reg};
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ptr_reg       <= PTR_IDLE;
            left_reg      <= 16'd0;
            pal_valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            left_reg  <= left_next;
            if (pal_we) begin
                pal_valid_reg[ptr_reg[7:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (plane_we) begin
            plane_mem[plane_addr] <= q_entry.data[7:0];
        end
        plane_q_reg <= plane_mem[plane_addr];
    end

    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[ptr_reg[7:0]] <= q_entry.data;
        end
        pal_q_reg <= pal_mem[plane_q_reg];
        pal_v_reg <= pal_valid_reg[plane_q_reg];
        idx_q_reg <= plane_q_reg;
    end

    a_pixel_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_entry.op == OP_PIXEL) |-> ##3 m_tvalid)
        else $error("pixel read did not reach the result register in three cycles");

    a_blank_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_entry.op == OP_BLANK) |=> (m_tvalid && out_reg == 24'd0))
        else $error("off-screen pixel did not give a black result");

    a_ptr_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        pal_we |=> (ptr_reg == $past(ptr_reg) + 9'd1 && left_reg == $past(left_reg) - 16'd1))
        else $error("palette write did not advance pointer and count together");

    a_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= PTR_IDLE)
        else $error("palette write pointer beyond the table end");

endmodule

/* src/planar_vga_palette_scanout_unit.sv */
// top level of the planar framebuffer with palette lookup and pixel readout
// a pixel read passes the front-end stage register and the queue before the back end;
// writes and palette commands retire one per cycle while the back end is idle; a pixel
// read holds the back end through plane memory read, palette memory read, result register
// reset clears queue and palette valid bits, idles load pointer; no clearing pass is run
// the palette reads as a greyscale ramp until entries are loaded
module planar_vga_palette_scanout_unit #(
    parameter int PLANE_BYTES   = 65536,
    parameter int LINE_STRIDE   = 160,
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 400
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // plane, offset, byte_value, start_index, load_count, color18, packed15, pixel_x, pixel_y
    input  logic [103:0] s_tdata,
    // command
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // red, green, blue
    output logic [23:0]  m_tdata
);
    import pvga_pkg::*;

    q_entry_t front_entry;
    q_entry_t head_entry;
    logic     front_push;
    logic     q_not_full;
    logic     q_not_empty;
    logic     back_pop;

    pvga_front #(
        .PLANE_BYTES   (PLANE_BYTES),
        .LINE_STRIDE   (LINE_STRIDE),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (front_push),
        .q_entry  (front_entry),
        .q_ready  (q_not_full)
    );

    pvga_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (front_push),
        .push_entry (front_entry),
        .not_full   (q_not_full),
        .pop        (back_pop),
        .not_empty  (q_not_empty),
        .head       (head_entry)
    );

    pvga_back #(
        .PLANE_BYTES (PLANE_BYTES)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_not_empty),
        .q_entry  (head_entry),
        .q_pop    (back_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* tb/planar_vga_palette_scanout_unit_tb.sv */
// self-checking testbench of the planar framebuffer palette scanout unit
module planar_vga_palette_scanout_unit_tb;
    import pvga_pkg::*;

    localparam int PLANE_BYTES   = 65536;
    localparam int LINE_STRIDE   = 160;
    localparam int SCREEN_W      = 640;
    localparam int SCREEN_H      = 400;
    localparam int N_ITEMS       = 1350;
    localparam int QUIET_FROM    = 1150;
    localparam int LONG_HOLD     = 300;

    // s_tdata field positions
    localparam int P_PLANE = 0;
    localparam int P_OFF   = 2;
    localparam int P_BYTE  = 18;
    localparam int P_START = 26;
    localparam int P_COUNT = 34;
    localparam int P_C18   = 50;
    localparam int P_P15   = 68;
    localparam int P_X     = 84;
    localparam int P_Y     = 94;

    class scanout_scoreboard;
        logic [7:0]  plane_mem [int];
        logic [23:0] palette [256];
        logic [8:0]  load_ptr;
        logic [15:0] load_left;
        logic [23:0] pending_rgb [$];
        int          n_errors;

        function new();
            for (int i = 0; i < 256; i++) begin
                palette[i] = {i[7:0], i[7:0], i[7:0]};
            end
            load_ptr  = PTR_IDLE;
            load_left = '0;
            n_errors  = 0;
        endfunction

        function logic [7:0] grow6(logic [5:0] v);
            logic [7:0] w;
            w = {2'b00, v};
            return (w << 2) | (w >> 4);
        endfunction

        function logic [7:0] grow5(logic [4:0] v);
            logic [7:0] w;
            w = {3'b000, v};
            return (w << 3) | (w >> 2);
        endfunction

        function void load_entry(logic [23:0] rgb);
            if (load_left == 0 || load_ptr >= PTR_IDLE) return;
            palette[load_ptr[7:0]] = rgb;
            load_ptr++;
            load_left--;
        endfunction

        function void note_command(logic [2:0] cmd, logic [103:0] d);
            int unsigned x;
            int unsigned y;
            int unsigned addr;
            logic [7:0]  idx;
            logic [23:0] rgb;
            logic [17:0] c18;
            logic [15:0] p15;
            c18 = d[P_C18 +: 18];
            p15 = d[P_P15 +: 16];
            case (cmd)
                CMD_WRITE: begin
                    plane_mem[int'(d[P_PLANE +: 2]) * PLANE_BYTES + int'(d[P_OFF +: 16])] =
                        d[P_BYTE +: 8];
                end
                CMD_BEGIN: begin
                    load_ptr  = {1'b0, d[P_START +: 8]};
                    load_left = d[P_COUNT +: 16];
                end
                CMD_ENTRY18: begin
                    load_entry({grow6(c18[17:12]), grow6(c18[11:6]), grow6(c18[5:0])});
                end
                CMD_ENTRY15: begin
                    load_entry({grow5(p15[14:10]), grow5(p15[9:5]), grow5(p15[4:0])});
                end
                CMD_PIXEL: begin
                    x   = d[P_X +: 10];
                    y   = d[P_Y +: 9];
                    rgb = '0;
                    if (x < SCREEN_W && y < SCREEN_H) begin
                        addr = (y * LINE_STRIDE + (x >> 2)) % PLANE_BYTES;
                        idx  = 8'h00;
                        if (plane_mem.exists(int'(x % 4) * PLANE_BYTES + int'(addr))) begin
                            idx = plane_mem[int'(x % 4) * PLANE_BYTES + int'(addr)];
                        end
                        rgb = palette[idx];
                    end
                    pending_rgb.push_back(rgb);
                end
                default: ;
            endcase
        endfunction

        function void check_pixel(logic [23:0] tdata);
            logic [23:0] want;
            if (pending_rgb.size() == 0) begin
                $error("unexpected result transaction: %0h", tdata);
                n_errors++;
                return;
            end
            want = pending_rgb.pop_front();
            if (tdata[7:0] !== want[23:16]) begin
                $error("red mismatch: expected %0h, actual %0h", want[23:16], tdata[7:0]);
                n_errors++;
            end
            if (tdata[15:8] !== want[15:8]) begin
                $error("green mismatch: expected %0h, actual %0h", want[15:8], tdata[15:8]);
                n_errors++;
            end
            if (tdata[23:16] !== want[7:0]) begin
                $error("blue mismatch: expected %0h, actual %0h", want[7:0], tdata[23:16]);
                n_errors++;
            end
        endfunction
    endclass

    typedef struct {
        int unsigned x;
        int unsigned y;
    } pix_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata  = '0;
    logic [2:0]   s_tuser  = CMD_WRITE;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;

    scanout_scoreboard sb = new();
    pix_t              written_pix [$];
    int                n_sent   = 0;
    bit                quiet    = 1'b0;
    int                hold_req = 0;

    planar_vga_palette_scanout_unit #(
        .PLANE_BYTES  (PLANE_BYTES),
        .LINE_STRIDE  (LINE_STRIDE),
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [103:0] noise();
        logic [127:0] r;
        r = {$urandom, $urandom, $urandom, $urandom};
        return {1'b0, r[102:0]};
    endfunction

    function automatic logic [103:0] mk_write(logic [1:0] plane, logic [15:0] off,
                                              logic [7:0] v);
        logic [103:0] d;
        d = noise();
        d[P_PLANE +: 2] = plane;
        d[P_OFF +: 16]  = off;
        d[P_BYTE +: 8]  = v;
        return d;
    endfunction

    function automatic logic [103:0] mk_begin(logic [7:0] start, logic [15:0] count);
        logic [103:0] d;
        d = noise();
        d[P_START +: 8]  = start;
        d[P_COUNT +: 16] = count;
        return d;
    endfunction

    function automatic logic [103:0] mk_entry18(logic [17:0] c);
        logic [103:0] d;
        d = noise();
        d[P_C18 +: 18] = c;
        return d;
    endfunction

    function automatic logic [103:0] mk_entry15(logic [15:0] p);
        logic [103:0] d;
        d = noise();
        d[P_P15 +: 16] = p;
        return d;
    endfunction

    function automatic logic [103:0] mk_pixel(int unsigned x, int unsigned y);
        logic [103:0] d;
        d = noise();
        d[P_X +: 10] = x[9:0];
        d[P_Y +: 9]  = y[8:0];
        return d;
    endfunction

    task automatic offer(logic [2:0] cmd, logic [103:0] d);
        s_tuser  <= cmd;
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_command(cmd, d);
        n_sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic store_pixel(int unsigned x, int unsigned y, logic [7:0] v);
        pix_t p;
        int unsigned off;
        p.x = x;
        p.y = y;
        off = y * LINE_STRIDE + x / 4;
        written_pix.push_back(p);
        offer(CMD_WRITE, mk_write(2'(x % 4), 16'(off), v));
    endtask

    task automatic read_pixel(int unsigned x, int unsigned y);
        offer(CMD_PIXEL, mk_pixel(x, y));
    endtask

    task automatic read_known();
        pix_t p;
        if (written_pix.size() == 0) begin
            store_pixel($urandom_range(0, SCREEN_W - 1), $urandom_range(0, SCREEN_H - 1),
                        8'($urandom));
        end else begin
            p = written_pix[$urandom_range(0, written_pix.size() - 1)];
            read_pixel(p.x, p.y);
        end
    endtask

    task automatic offer_entry();
        if ($urandom_range(0, 1)) offer(CMD_ENTRY18, mk_entry18(18'($urandom)));
        else offer(CMD_ENTRY15, mk_entry15(16'($urandom)));
    endtask

    task automatic palette_burst();
        int          sel;
        int          n;
        logic [15:0] count;
        sel = $urandom_range(0, 9);
        if (sel == 0) count = '0;
        else if (sel == 1) count = 16'hFFFF;
        else count = 16'($urandom_range(1, 20));
        offer(CMD_BEGIN, mk_begin(8'($urandom), count));
        n = $urandom_range(1, 24);
        repeat (n) offer_entry();
    endtask

    // result side: sample handshake, then pick next tready
    initial begin
        int stall;
        stall = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid === 1'b1 && m_tready) sb.check_pixel(m_tdata);
            if (hold_req > 0) begin
                stall    = hold_req;
                hold_req = 0;
            end
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall    = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #800000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int   pick;
        bit   hold_done;
        bit   drain_done;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corners of the screen and plane, offscreen reads, load edges
        store_pixel(0, 0, 8'h00);
        store_pixel(SCREEN_W - 1, SCREEN_H - 1, 8'hFF);
        offer(CMD_WRITE, mk_write(2'd1, 16'hFFFF, 8'h80));
        read_pixel(0, 0);
        read_pixel(SCREEN_W - 1, SCREEN_H - 1);
        read_pixel(SCREEN_W, 0);
        read_pixel(0, SCREEN_H);
        read_pixel(1023, 511);
        offer(CMD_BEGIN, mk_begin(8'hFF, 16'd3));
        offer(CMD_ENTRY18, mk_entry18(18'h3FFFF));
        offer(CMD_ENTRY18, mk_entry18(18'h00000));
        read_pixel(SCREEN_W - 1, SCREEN_H - 1);
        offer(CMD_BEGIN, mk_begin(8'h00, 16'd2));
        offer(CMD_ENTRY18, mk_entry18(18'h2A5C3));
        offer(CMD_ENTRY15, mk_entry15(16'hFFFF));
        offer(CMD_ENTRY15, mk_entry15(16'h7C1F));
        read_pixel(0, 0);
        store_pixel(1, 0, 8'h01);
        read_pixel(1, 0);
        for (int k = 1; k <= 3; k++) begin
            offer(CMD_PIXEL + 3'(k), noise());
        end
        offer(CMD_BEGIN, mk_begin(8'h05, 16'd0));
        offer(CMD_ENTRY15, mk_entry15(16'h0000));
        offer(CMD_BEGIN, mk_begin(8'h00, 16'hFFFF));

        while (n_sent < N_ITEMS) begin
            if (!hold_done && n_sent >= 500) begin
                // long result stall while reads keep coming
                hold_done = 1'b1;
                quiet     = 1'b1;
                hold_req  = LONG_HOLD;
                repeat (40) read_known();
                quiet     = 1'b0;
            end
            if (!drain_done && n_sent >= 800) begin
                drain_done = 1'b1;
                s_tvalid <= 1'b0;
                while (sb.pending_rgb.size() != 0) @(posedge aclk);
            end
            quiet = (n_sent >= QUIET_FROM);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                store_pixel($urandom_range(0, SCREEN_W - 1), $urandom_range(0, SCREEN_H - 1),
                            8'($urandom));
            end else if (pick < 35) begin
                offer(CMD_WRITE, mk_write(2'($urandom), 16'($urandom), 8'($urandom)));
            end else if (pick < 65) begin
                read_known();
            end else if (pick < 70) begin
                if ($urandom_range(0, 1)) read_pixel($urandom_range(SCREEN_W, 1023),
                                                     $urandom_range(0, 511));
                else read_pixel($urandom_range(0, 1023), $urandom_range(SCREEN_H, 511));
            end else if (pick < 85) begin
                palette_burst();
            end else if (pick < 90) begin
                offer_entry();
            end else if (pick < 93) begin
                offer(CMD_PIXEL + 3'($urandom_range(1, 3)), noise());
            end else begin
                read_known();
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending_rgb.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.n_errors == 0 && sb.pending_rgb.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
